// ===== hw/rtl/rfp_pkg.sv =====
// shared types, constants and a helper function for the tag-reader frame parser
package rfp_pkg;

    // frame layout
    localparam int unsigned FrameBytes   = 14;
    localparam int unsigned PosWidth     = 4;
    localparam logic [PosWidth-1:0] LastPos = PosWidth'(FrameBytes - 1);
    localparam int unsigned NibbleBits   = 48;
    localparam int unsigned GapWidth     = 16;
    localparam int unsigned TagWidth     = 32;
    localparam logic [GapWidth-1:0] GapMax = '1;
    localparam logic [TagWidth-1:0] SinceMax = '1;

    // stream payload widths
    localparam int unsigned InDataWidth  = 8;
    localparam int unsigned InUserWidth  = 2;
    localparam int unsigned OutDataWidth = 72;

    // configuration port
    localparam int unsigned ApbAddrWidth = 4;
    localparam int unsigned ApbDataWidth = 32;

    // item kinds
    typedef enum logic [1:0] {
        OP_BYTE = 2'd0,
        OP_TICK = 2'd1,
        OP_ACK  = 2'd2,
        OP_NOP  = 2'd3
    } t_opcode;

    // per-item frame status
    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_ACCEPTED  = 3'd1,
        ST_BAD_END   = 3'd2,
        ST_BAD_SUM   = 3'd3,
        ST_BAD_HEX   = 3'd4,
        ST_TIMEOUT   = 3'd5,
        ST_SYNC_DROP = 3'd6
    } t_frame_status;

    // register indexes (paddr[3:2])
    typedef enum logic [1:0] {
        REG_TAG_TIMEOUT  = 2'd0,
        REG_READ_TIMEOUT = 2'd1,
        REG_BEGIN_BYTE   = 2'd2,
        REG_END_BYTE     = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [31:0] tag_hold_ms;
        logic [15:0] read_timeout_ms;
        logic [7:0]  begin_byte;
        logic [7:0]  end_byte;
    } t_cfg;

    typedef struct packed {
        t_frame_status frame_status;
        logic [TagWidth-1:0] pending_new_tag;
        logic [TagWidth-1:0] present_tag;
    } t_result;

    // ascii hex digit decode: bit 4 set when the byte is a hex digit
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/rfp_cfg_regs.sv =====
// apb configuration registers of the frame parser
module rfp_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rfp_pkg::ApbAddrWidth-1:0]   paddr,
    input  logic [rfp_pkg::ApbDataWidth-1:0]   pwdata,
    output logic [rfp_pkg::ApbDataWidth-1:0]   prdata,
    output logic                               pready,
    output rfp_pkg::t_cfg                      o_cfg
);

    rfp_pkg::t_cfg      r_cfg;
    rfp_pkg::t_reg_idx  w_idx;
    logic               w_wr;

    assign pready = 1'b1;
    assign w_idx  = rfp_pkg::t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tag_hold_ms     <= 32'd300;
            r_cfg.read_timeout_ms <= 16'd50;
            r_cfg.begin_byte      <= 8'd2;
            r_cfg.end_byte        <= 8'd3;
        end else if (w_wr) begin
            case (w_idx)
                rfp_pkg::REG_TAG_TIMEOUT:  r_cfg.tag_hold_ms     <= pwdata;
                rfp_pkg::REG_READ_TIMEOUT: r_cfg.read_timeout_ms <= pwdata[15:0];
                rfp_pkg::REG_BEGIN_BYTE:   r_cfg.begin_byte      <= pwdata[7:0];
                rfp_pkg::REG_END_BYTE:     r_cfg.end_byte        <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (w_idx)
            rfp_pkg::REG_TAG_TIMEOUT:  prdata = r_cfg.tag_hold_ms;
            rfp_pkg::REG_READ_TIMEOUT: prdata = {16'd0, r_cfg.read_timeout_ms};
            rfp_pkg::REG_BEGIN_BYTE:   prdata = {24'd0, r_cfg.begin_byte};
            rfp_pkg::REG_END_BYTE:     prdata = {24'd0, r_cfg.end_byte};
            default:                   prdata = '0;
        endcase
    end

endmodule

// ===== hw/rtl/rfp_core.sv =====
// frame assembly, checksum and tag presence state, one item per step
module rfp_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  rfp_pkg::t_opcode  i_op,
    input  logic [7:0]        i_byte,
    input  rfp_pkg::t_cfg     i_cfg,
    output rfp_pkg::t_result  o_result
);

    logic [rfp_pkg::PosWidth-1:0]   r_pos,     n_pos;
    logic [rfp_pkg::NibbleBits-1:0] r_nibbles, n_nibbles;
    logic                           r_fault,   n_fault;
    logic [rfp_pkg::GapWidth-1:0]   r_gap,     n_gap;
    logic [rfp_pkg::TagWidth-1:0]   r_cur,     n_cur;
    logic [rfp_pkg::TagWidth-1:0]   r_new,     n_new;
    logic [rfp_pkg::TagWidth-1:0]   r_since,   n_since;

    logic [4:0]                     w_hex;
    logic [7:0]                     w_ver, w_sum, w_xor;
    logic [rfp_pkg::TagWidth-1:0]   w_tag;
    logic [rfp_pkg::GapWidth-1:0]   w_gap_inc;
    logic [rfp_pkg::TagWidth-1:0]   w_since_inc;
    logic [rfp_pkg::TagWidth-1:0]   w_shown;
    rfp_pkg::t_frame_status         w_status;

    // frame fields and checksum
    assign w_hex  = rfp_pkg::hex_decode(i_byte);
    assign w_ver  = r_nibbles[47:40];
    assign w_tag  = r_nibbles[39:8];
    assign w_sum  = r_nibbles[7:0];
    assign w_xor  = w_ver ^ w_tag[31:24] ^ w_tag[23:16] ^ w_tag[15:8] ^ w_tag[7:0];

    // saturating counters
    assign w_gap_inc   = (r_gap == rfp_pkg::GapMax) ? r_gap : r_gap + 1'b1;
    assign w_since_inc = (r_since == rfp_pkg::SinceMax) ? r_since : r_since + 1'b1;

    // next state and status
    always_comb begin
        n_pos     = r_pos;
        n_nibbles = r_nibbles;
        n_fault   = r_fault;
        n_gap     = r_gap;
        n_cur     = r_cur;
        n_new     = r_new;
        n_since   = r_since;
        w_status  = rfp_pkg::ST_IDLE;
        w_shown   = r_new;
        case (i_op)
            rfp_pkg::OP_BYTE: begin
                if (r_pos == '0) begin
                    if (i_byte != i_cfg.begin_byte) begin
                        w_status = rfp_pkg::ST_SYNC_DROP;
                    end else begin
                        n_pos     = rfp_pkg::PosWidth'(1);
                        n_nibbles = '0;
                        n_fault   = 1'b0;
                        n_gap     = '0;
                    end
                end else begin
                    n_gap = '0;
                    if (r_pos >= rfp_pkg::LastPos) begin
                        n_pos = '0;
                        if (i_byte != i_cfg.end_byte) begin
                            w_status = rfp_pkg::ST_BAD_END;
                        end else if (r_fault) begin
                            w_status = rfp_pkg::ST_BAD_HEX;
                        end else if (w_xor != w_sum) begin
                            w_status = rfp_pkg::ST_BAD_SUM;
                        end else begin
                            w_status = rfp_pkg::ST_ACCEPTED;
                            if (w_tag != '0) begin
                                if (r_cur != w_tag) begin
                                    n_new = w_tag;
                                end
                                n_cur   = w_tag;
                                n_since = '0;
                            end
                        end
                    end else begin
                        n_nibbles = {r_nibbles[rfp_pkg::NibbleBits-5:0], w_hex[3:0]};
                        n_fault   = r_fault | ~w_hex[4];
                        n_pos     = r_pos + 1'b1;
                    end
                end
                w_shown = n_new;
            end
            rfp_pkg::OP_TICK: begin
                if (r_pos != '0) begin
                    if (w_gap_inc > i_cfg.read_timeout_ms) begin
                        n_pos    = '0;
                        n_gap    = '0;
                        w_status = rfp_pkg::ST_TIMEOUT;
                    end else begin
                        n_gap = w_gap_inc;
                    end
                end
                n_since = w_since_inc;
                if (r_cur != '0 && w_since_inc >= i_cfg.tag_hold_ms) begin
                    n_cur = '0;
                    n_new = '0;
                end
                w_shown = n_new;
            end
            rfp_pkg::OP_ACK: begin
                n_new = '0;
            end
            default: ;
        endcase
    end

    assign o_result.present_tag     = n_cur;
    assign o_result.pending_new_tag = w_shown;
    assign o_result.frame_status    = w_status;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_nibbles <= '0;
            r_fault   <= 1'b0;
            r_gap     <= '0;
            r_cur     <= '0;
            r_new     <= '0;
            r_since   <= '0;
        end else if (i_step) begin
            r_pos     <= n_pos;
            r_nibbles <= n_nibbles;
            r_fault   <= n_fault;
            r_gap     <= n_gap;
            r_cur     <= n_cur;
            r_new     <= n_new;
            r_since   <= n_since;
        end
    end

endmodule

// ===== hw/rtl/rfid_frame_parser_presence.sv =====
// top level of the serial tag-reader frame parser with presence tracking
//
// channel   dir   handshake          payload
// s_*       in    s_tvalid/s_tready  tuser[1:0] opcode, tdata[7:0] byte_value
// m_*       out   m_tvalid/m_tready  tdata present_tag, pending_new_tag, frame_status
// apb       in    psel/penable       four registers at byte addresses 0, 4, 8, 12
//
// one item per cycle while m_* is not stalled; an accepted beat lands in the input
// register, is processed by the core as it moves into the output register and is
// then offered on m_*. state updates only when the item moves into the output
// register, so a stall on m_tready holds everything in place.
// synchronous active-low reset clears the frame state, the tags and the
// registers (tag timeout 300, read timeout 50, begin 2, end 3).
module rfid_frame_parser_presence (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [rfp_pkg::InDataWidth-1:0]     s_tdata,  // [7:0] byte_value
    input  logic [rfp_pkg::InUserWidth-1:0]     s_tuser,  // [1:0] opcode
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [31:0] present_tag, [63:32] pending_new_tag, [66:64] frame_status, rest zero
    output logic [rfp_pkg::OutDataWidth-1:0]    m_tdata,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rfp_pkg::ApbAddrWidth-1:0]    paddr,
    input  logic [rfp_pkg::ApbDataWidth-1:0]    pwdata,
    output logic [rfp_pkg::ApbDataWidth-1:0]    prdata,
    output logic                                pready
);

    rfp_pkg::t_cfg     w_cfg;
    rfp_pkg::t_result  w_result;

    logic              r_in_valid;
    rfp_pkg::t_opcode  r_in_op;
    logic [7:0]        r_in_byte;
    logic              r_out_valid;
    rfp_pkg::t_result  r_out;
    logic              w_advance;
    logic              w_in_take;

    // pipeline flow control
    assign w_advance = r_in_valid & (~r_out_valid | m_tready);
    assign s_tready  = ~r_in_valid | w_advance;
    assign w_in_take = s_tvalid & s_tready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_op   <= rfp_pkg::t_opcode'(s_tuser);
            r_in_byte <= s_tdata;
        end
    end

    rfp_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    rfp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_op     (r_in_op),
        .i_byte   (r_in_byte),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {5'd0, r_out};

endmodule

// ===== test/tb_top.sv =====
// self-checking testbench for the tag-reader frame parser with presence tracking
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rfp_pkg::*;

    localparam int FrameLen = 14;

    typedef struct {
        t_opcode     op;
        logic [7:0]  data;
        int unsigned pause;
    } t_reader_item;

    // clock, reset and block ports
    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;   // [7:0] byte_value
    logic [1:0]  s_tuser = '0;   // [1:0] opcode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;        // [31:0] present_tag, [63:32] pending_new_tag, [66:64] status
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    rfid_frame_parser_presence i_dut (
        .i_clk, .i_rst_n,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // parser state as the testbench sees it
    t_cfg        cfg_now  = '{32'd300, 16'd50, 8'd2, 8'd3};
    logic [3:0]  frm_pos  = '0;
    logic [47:0] nibbles  = '0;
    logic        hex_bad  = 1'b0;
    logic [15:0] gap_ms   = '0;
    logic [31:0] cur_tag  = '0;
    logic [31:0] pend_tag = '0;
    logic [31:0] since_ms = '0;

    t_reader_item pending_items[$];
    t_result      tag_reports[$];
    t_reader_item cur_item;
    logic         offering = 1'b0;
    int unsigned  pause_cnt;
    int unsigned  recv_wait, quiet_left, send_burst_left;
    int unsigned  hold_left, hold_cool, holds_done;
    logic         long_hold = 1'b0;

    int errors, items_queued, results_seen, settings_used;
    int frames_ok, frames_bad, read_drops, sync_drops, tag_expiries;

    logic [31:0] tag_pool [4] = '{32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'h1234_ABCD};

    function automatic logic is_hex_char(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46)
            || (c >= 8'h61 && c <= 8'h66);
    endfunction

    // one item through the parser, returns what the block must report
    function automatic t_result parse_step(input t_opcode op, input logic [7:0] b);
        t_result       r;
        t_frame_status st;
        logic [31:0]   shown, tag;
        logic [7:0]    ver, sum, fold, val;
        st = ST_IDLE;
        case (op)
            OP_BYTE: begin
                if (frm_pos == 0) begin
                    if (b != cfg_now.begin_byte) begin
                        st = ST_SYNC_DROP;
                    end else begin
                        frm_pos = 4'd1;
                        nibbles = '0;
                        hex_bad = 1'b0;
                        gap_ms  = '0;
                    end
                end else begin
                    gap_ms = '0;
                    if (frm_pos >= FrameLen - 1) begin
                        // end byte first, then digits, then checksum
                        frm_pos = '0;
                        ver = nibbles[47:40];
                        tag = nibbles[39:8];
                        sum = nibbles[7:0];
                        fold = ver ^ tag[7:0] ^ tag[15:8] ^ tag[23:16] ^ tag[31:24];
                        if (b != cfg_now.end_byte) begin
                            st = ST_BAD_END;
                        end else if (hex_bad) begin
                            st = ST_BAD_HEX;
                        end else if (fold != sum) begin
                            st = ST_BAD_SUM;
                        end else begin
                            st = ST_ACCEPTED;
                            if (tag != 0) begin
                                if (cur_tag != tag) pend_tag = tag;
                                cur_tag  = tag;
                                since_ms = '0;
                            end
                        end
                    end else begin
                        // non-hex digit counts as zero and marks the frame
                        if (!is_hex_char(b)) begin
                            hex_bad = 1'b1;
                            val = 8'd0;
                        end else if (b >= 8'h61) begin
                            val = b - 8'h57;
                        end else if (b >= 8'h41) begin
                            val = b - 8'h37;
                        end else begin
                            val = b - 8'h30;
                        end
                        nibbles = {nibbles[43:0], val[3:0]};
                        frm_pos = frm_pos + 4'd1;
                    end
                end
                shown = pend_tag;
            end
            OP_TICK: begin
                if (frm_pos != 0) begin
                    if (gap_ms != '1) gap_ms = gap_ms + 16'd1;
                    if (gap_ms > cfg_now.read_timeout_ms) begin
                        frm_pos = '0;
                        gap_ms  = '0;
                        st = ST_TIMEOUT;
                    end
                end
                if (since_ms != '1) since_ms = since_ms + 32'd1;
                if (cur_tag != 0 && since_ms >= cfg_now.tag_hold_ms) begin
                    cur_tag  = '0;
                    pend_tag = '0;
                    tag_expiries++;
                end
                shown = pend_tag;
            end
            OP_ACK: begin
                shown = pend_tag;
                pend_tag = '0;
            end
            default: shown = pend_tag;
        endcase
        r.present_tag     = cur_tag;
        r.pending_new_tag = shown;
        r.frame_status    = st;
        return r;
    endfunction

    function automatic void note_fault(input string what, input logic [31:0] want,
                                       input logic [31:0] got);
        errors++;
        if (errors <= 10)
            $display("%0t: %s mismatch, expected %h got %h", $realtime, what, want, got);
    endfunction

    // input driver: offers queued items, predicts each accepted beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            offering  = 1'b0;
            pause_cnt = 0;
        end else begin
            if (offering && s_tready) begin
                tag_reports.push_back(parse_step(cur_item.op, cur_item.data));
                offering = 1'b0;
            end
            if (!offering && pending_items.size() > 0) begin
                if (pause_cnt < pending_items[0].pause) begin
                    pause_cnt++;
                end else begin
                    cur_item  = pending_items.pop_front();
                    pause_cnt = 0;
                    offering  = 1'b1;
                    s_tdata  <= cur_item.data;
                    s_tuser  <= cur_item.op;
                end
            end
        end
        s_tvalid <= offering;
    end

    // result monitor with random back-pressure
    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            recv_wait  = 0;
            quiet_left = 0;
        end else if (m_tvalid && m_tready) begin
            got = t_result'(m_tdata[66:0]);
            results_seen++;
            case (got.frame_status)
                ST_ACCEPTED: frames_ok++;
                ST_BAD_END, ST_BAD_SUM, ST_BAD_HEX: frames_bad++;
                ST_TIMEOUT: read_drops++;
                ST_SYNC_DROP: sync_drops++;
                default: ;
            endcase
            if (m_tdata[71:67] != '0) note_fault("padding", '0, 32'(m_tdata[71:67]));
            if (tag_reports.size() == 0) begin
                note_fault("unexpected result", '0, got.present_tag);
            end else begin
                want = tag_reports.pop_front();
                if (got.present_tag != want.present_tag)
                    note_fault("present_tag", want.present_tag, got.present_tag);
                if (got.pending_new_tag != want.pending_new_tag)
                    note_fault("pending_new_tag", want.pending_new_tag, got.pending_new_tag);
                if (got.frame_status != want.frame_status)
                    note_fault("frame_status", 32'(want.frame_status), 32'(got.frame_status));
            end
            // stretches with no stall now and then
            if (quiet_left > 0) begin
                recv_wait = 0;
                quiet_left--;
            end else begin
                recv_wait = $urandom_range(0, 3);
                if ($urandom_range(0, 49) == 0) quiet_left = 40;
            end
        end else if (recv_wait > 0) begin
            recv_wait--;
        end
        m_tready <= i_rst_n && !long_hold && recv_wait == 0;
    end

    // long receiver hold-off, started while more than 100 items wait in the input queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left  = 0;
            hold_cool  = 0;
            holds_done = 0;
        end else begin
            if (hold_cool > 0) hold_cool--;
            if (hold_left > 0) begin
                hold_left--;
            end else if (holds_done < 3 && hold_cool == 0 && pending_items.size() > 100) begin
                hold_left  = 150;
                hold_cool  = 2000;
                holds_done++;
            end
        end
        long_hold <= hold_left > 0;
    end

    task automatic push_item(input t_opcode op, input logic [7:0] data);
        t_reader_item it;
        it.op   = op;
        it.data = data;
        if (send_burst_left > 0) begin
            it.pause = 0;
            send_burst_left--;
        end else begin
            it.pause = $urandom_range(0, 3);
            if ($urandom_range(0, 39) == 0) send_burst_left = 30;
        end
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic push_ticks(input int n);
        for (int i = 0; i < n; i++) push_item(OP_TICK, 8'($urandom));
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return 8'h30 + v;
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + v - 8'd10;
    endfunction

    // one frame, good or broken in one of several ways
    task automatic push_frame();
        int          kind, bad_at, cut, room;
        logic [7:0]  ver, sum, ending, c;
        logic [31:0] tag;
        logic [47:0] digits;
        kind = $urandom_range(0, 9);
        ver  = 8'($urandom);
        tag  = ($urandom_range(0, 2) == 0) ? tag_pool[$urandom_range(0, 3)] : $urandom;
        if (kind == 4) tag = '0;
        sum = ver ^ tag[7:0] ^ tag[15:8] ^ tag[23:16] ^ tag[31:24];
        if (kind == 7) sum = sum ^ 8'($urandom_range(1, 255));
        digits = {ver, tag, sum};
        bad_at = (kind == 6) ? $urandom_range(0, 11) : -1;
        cut    = (kind == 8) ? $urandom_range(0, 12) : 13;
        room   = (cfg_now.read_timeout_ms < 20) ? cfg_now.read_timeout_ms : 20;
        push_item(OP_BYTE, cfg_now.begin_byte);
        for (int i = 0; i < 12 && i < cut; i++) begin
            if (i == bad_at) begin
                do c = 8'($urandom); while (is_hex_char(c));
            end else begin
                c = hex_char(digits[47 - 4*i -: 4]);
            end
            push_item(OP_BYTE, c);
            if (kind == 9 && $urandom_range(0, 3) == 0) push_ticks($urandom_range(0, room));
        end
        if (kind == 8) begin
            if (cfg_now.read_timeout_ms <= 200) push_ticks(cfg_now.read_timeout_ms + 1);
            else push_ticks($urandom_range(1, 5));
        end else begin
            ending = (kind == 5) ? cfg_now.end_byte ^ 8'($urandom_range(1, 255))
                                 : cfg_now.end_byte;
            push_item(OP_BYTE, ending);
        end
    endtask

    // register write followed by a read-back
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        logic [31:0] kept;
        case (idx)
            REG_TAG_TIMEOUT:  kept = value;
            REG_READ_TIMEOUT: kept = {16'd0, value[15:0]};
            REG_BEGIN_BYTE:   kept = {24'd0, value[7:0]};
            default:          kept = {24'd0, value[7:0]};
        endcase
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TAG_TIMEOUT:  cfg_now.tag_hold_ms     = kept;
            REG_READ_TIMEOUT: cfg_now.read_timeout_ms = kept[15:0];
            REG_BEGIN_BYTE:   cfg_now.begin_byte      = kept[7:0];
            default:          cfg_now.end_byte        = kept[7:0];
        endcase
        @(posedge i_clk);
        psel <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== kept) note_fault("register read-back", kept, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || offering || tag_reports.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // one register setting and a random stream under it
    task automatic run_phase(input logic [31:0] tag_to, input logic [15:0] read_to,
                             input logic [7:0] begin_b, input logic [7:0] end_b,
                             input int n);
        int start, pick;
        write_reg(REG_TAG_TIMEOUT, tag_to);
        write_reg(REG_READ_TIMEOUT, {16'($urandom_range(0, 65535)), read_to});
        write_reg(REG_BEGIN_BYTE, {24'($urandom), begin_b});
        write_reg(REG_END_BYTE, {24'($urandom), end_b});
        settings_used++;
        start = items_queued;
        while (items_queued - start < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                push_frame();
            end else if (pick < 70) begin
                if (cfg_now.tag_hold_ms <= 64 && $urandom_range(0, 5) == 0)
                    push_ticks(cfg_now.tag_hold_ms + 1);
                else
                    push_ticks($urandom_range(1, 8));
            end else if (pick < 80) begin
                push_item(OP_ACK, 8'($urandom));
            end else if (pick < 90) begin
                push_item(OP_BYTE, 8'($urandom));
            end else begin
                push_item(OP_NOP, 8'($urandom));
            end
        end
        drain();
    endtask

    // stimulus sequence
    initial begin
        string id_text;
        id_text = "5ec0ffee018e";
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset settings, drops, unused opcode, lower-case frame, acks
        settings_used = 1;
        push_item(OP_BYTE, 8'h00);
        push_item(OP_BYTE, 8'hFF);
        push_item(OP_NOP, 8'hA5);
        push_item(OP_ACK, 8'h5A);
        push_item(OP_TICK, 8'h00);
        push_item(OP_BYTE, 8'h02);
        for (int i = 0; i < id_text.len(); i++) push_item(OP_BYTE, id_text[i]);
        push_item(OP_BYTE, 8'h03);
        push_item(OP_ACK, 8'hFF);
        push_item(OP_ACK, 8'h00);
        drain();

        run_phase(32'd40, 16'd5, 8'h02, 8'h03, 340);
        run_phase(32'd0, 16'd0, 8'h00, 8'hFF, 340);
        run_phase(32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 8'h00, 340);
        run_phase($urandom_range(1, 60), 16'($urandom_range(0, 10)), 8'($urandom),
                  8'($urandom), 340);
        run_phase(32'd300, 16'd50, 8'h02, 8'h03, 340);
        repeat (10) @(posedge i_clk);

        $display("%0d beats in, %0d results checked, %0d register settings, %0d long stalls",
                 items_queued, results_seen, settings_used, holds_done);
        $display("frames accepted %0d, rejected %0d, read drops %0d, sync drops %0d, expiries %0d",
                 frames_ok, frames_bad, read_drops, sync_drops, tag_expiries);
        if (errors == 0 && tag_reports.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
